// ===== rtl/nfp_pkg.sv =====
// ----------------------------------------------------------------------------
// nfp_pkg
// Shared constants and codes for the next-fit partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package nfp_pkg;

    // default configuration of the partition table
    localparam int MAX_PARTS_DEF   = 16;
    localparam int SIZE_BITS_DEF   = 16;

    // fixed widths of the port fields
    localparam int MEM_FIELD_W     = 16;
    localparam int IDX_FIELD_W     = 4;
    localparam int STATUS_W        = 3;

    // total memory after reset, in MB
    localparam int TOTAL_MEM_RESET = 4096;

    // command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED      = 3'd0,
        ST_NO_ROOM    = 3'd1,
        ST_ALLOCATED  = 3'd2,
        ST_NOT_ALLOC  = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/nfp_ram.sv =====
// ----------------------------------------------------------------------------
// nfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nfp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/next_fit_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// next_fit_partition_allocator
// Fixed-partition memory manager with next-fit placement over a table in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken when start is high and busy is low.
//   cmd selects add-partition or allocate, size carries the size in MB.
//   Each command gives exactly one result beat, marked by done for one
//   cycle, carrying status, part_index and memory_left. The receiver
//   cannot stall; a result is shown once and must be taken then.
//   Config: cfg_we writes cfg_wdata into total_memory; write only when idle.
// Sequencing:
//   An add, a full table or an allocate on an empty table is answered
//   in the cycle after the command beat.
//   An allocate walks the carved partitions one per cycle through the
//   table RAM (one registered read port), starting at the last allocated
//   index: it answers on the first free entry that fits, or with a miss
//   once all part_count entries have been tested.
//   One command is in flight at a time.
// Reset:
//   Clears the partition count, carved and used totals, the last index
//   and restores total_memory to 4096. The RAM needs no clearing pass:
//   only entries below the partition count are read, and each was written
//   by an add after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module next_fit_partition_allocator #(
    parameter int MAX_PARTS = nfp_pkg::MAX_PARTS_DEF,
    parameter int SIZE_BITS = nfp_pkg::SIZE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            cmd,
    input  wire logic [nfp_pkg::MEM_FIELD_W-1:0] size,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [nfp_pkg::MEM_FIELD_W-1:0] cfg_wdata,
    // result channel
    output logic                                 done,
    output logic [nfp_pkg::STATUS_W-1:0]         status,
    output logic [nfp_pkg::IDX_FIELD_W-1:0]      part_index,
    output logic [nfp_pkg::MEM_FIELD_W-1:0]      memory_left
);

    localparam int IDX_W   = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNT_W   = $clog2(MAX_PARTS + 1);
    localparam int ENTRY_W = SIZE_BITS + 1;

    localparam logic [31:0]        TOT_RST32 = 32'(nfp_pkg::TOTAL_MEM_RESET);
    localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(MAX_PARTS);
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    nfp_pkg::state_t        state_reg, state_next;
    logic [SIZE_BITS-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SIZE_BITS-1:0]   carved_reg, carved_next;
    logic [SIZE_BITS-1:0]   used_reg, used_next;
    logic [IDX_W-1:0]       last_reg, last_next;

    logic [SIZE_BITS-1:0]   req_reg, req_next;
    logic [IDX_W-1:0]       issue_idx_reg, issue_idx_next;
    logic [CNT_W-1:0]       issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]       check_cnt_reg, check_cnt_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;

    logic                   done_reg, done_next;
    logic [nfp_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]       res_idx_reg, res_idx_next;

    // ------------------------------------------------------------------------
    // table ram: {busy, size} per partition
    // ------------------------------------------------------------------------
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [ENTRY_W-1:0]     ram_rdata;

    nfp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTS),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_idx_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // field width adaptation
    // ------------------------------------------------------------------------
    logic [31:0]            size_ext;
    logic [31:0]            cfg_ext;
    logic [SIZE_BITS-1:0]   size_w;
    logic [SIZE_BITS-1:0]   cfg_w;

    assign size_ext = 32'(size);
    assign cfg_ext  = 32'(cfg_wdata);
    assign size_w   = size_ext[SIZE_BITS-1:0];
    assign cfg_w    = cfg_ext[SIZE_BITS-1:0];

    // ------------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------------
    logic                   accept;
    logic [SIZE_BITS:0]     carve_sum;
    logic                   carve_fits;
    logic                   table_full;
    logic                   entry_busy;
    logic [SIZE_BITS-1:0]   entry_size;
    logic                   hit;
    logic [SIZE_BITS:0]     used_sum;
    logic [SIZE_BITS-1:0]   used_sat;
    logic                   issue_wrap;

    assign accept     = start && (state_reg == nfp_pkg::S_IDLE);
    assign carve_sum  = {1'b0, size_w} + {1'b0, carved_reg};
    assign carve_fits = carve_sum <= {1'b0, total_reg};
    assign table_full = count_reg == CNT_FULL;

    // entry under test
    assign entry_busy = ram_rdata[SIZE_BITS];
    assign entry_size = ram_rdata[SIZE_BITS-1:0];
    assign hit        = chk_valid_reg && !entry_busy && (entry_size >= req_reg);

    // saturating used total
    assign used_sum = {1'b0, used_reg} + {1'b0, req_reg};
    assign used_sat = used_sum[SIZE_BITS] ? SIZE_MAX : used_sum[SIZE_BITS-1:0];

    // read address walks up to the last carved entry, then wraps to zero
    assign issue_wrap = (CNT_W'(issue_idx_reg) + CNT_W'(1)) == count_reg;
    assign ram_re     = (state_reg == nfp_pkg::S_SCAN) && (issue_cnt_reg != '0);

    // ------------------------------------------------------------------------
    // control and next-state logic
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        carved_next    = carved_reg;
        used_next      = used_reg;
        last_next      = last_reg;
        req_next       = req_reg;
        issue_idx_next = issue_idx_reg;
        issue_cnt_next = issue_cnt_reg;
        check_cnt_next = check_cnt_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        res_idx_next   = res_idx_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = {1'b0, size_w};

        // configuration write
        if (cfg_we)
        begin
            total_next = cfg_w;
        end

        case (state_reg)
            nfp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next = size_w;
                    if (cmd == nfp_pkg::CMD_ADD)
                    begin
                        // carve a new partition
                        done_next    = 1'b1;
                        res_idx_next = '0;
                        if (table_full)
                        begin
                            status_next = nfp_pkg::ST_TABLE_FULL;
                        end
                        else if (!carve_fits)
                        begin
                            status_next = nfp_pkg::ST_NO_ROOM;
                        end
                        else
                        begin
                            status_next  = nfp_pkg::ST_ADDED;
                            res_idx_next = count_reg[IDX_W-1:0];
                            ram_we       = 1'b1;
                            carved_next  = carve_sum[SIZE_BITS-1:0];
                            count_next   = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // nothing carved yet
                        done_next    = 1'b1;
                        status_next  = nfp_pkg::ST_NOT_ALLOC;
                        res_idx_next = '0;
                    end
                    else
                    begin
                        // start the next-fit walk at the last index
                        state_next     = nfp_pkg::S_SCAN;
                        issue_idx_next = last_reg;
                        issue_cnt_next = count_reg;
                        check_cnt_next = count_reg;
                    end
                end
            end

            nfp_pkg::S_SCAN:
            begin
                // issue the next table read
                if (ram_re)
                begin
                    issue_cnt_next = issue_cnt_reg - CNT_W'(1);
                    issue_idx_next = issue_wrap ? '0 : IDX_W'(issue_idx_reg + 1'b1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_idx_reg;
                end

                // test the entry that came back
                if (hit)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = chk_idx_reg;
                    ram_wdata      = {1'b1, entry_size};
                    last_next      = chk_idx_reg;
                    used_next      = used_sat;
                    done_next      = 1'b1;
                    status_next    = nfp_pkg::ST_ALLOCATED;
                    res_idx_next   = chk_idx_reg;
                    chk_valid_next = 1'b0;
                    state_next     = nfp_pkg::S_IDLE;
                end
                else if (chk_valid_reg)
                begin
                    check_cnt_next = check_cnt_reg - CNT_W'(1);
                    if (check_cnt_reg == CNT_W'(1))
                    begin
                        done_next      = 1'b1;
                        status_next    = nfp_pkg::ST_NOT_ALLOC;
                        res_idx_next   = '0;
                        chk_valid_next = 1'b0;
                        state_next     = nfp_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = nfp_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfp_pkg::S_IDLE;
            total_reg     <= TOT_RST32[SIZE_BITS-1:0];
            count_reg     <= '0;
            carved_reg    <= '0;
            used_reg      <= '0;
            last_reg      <= '0;
            issue_cnt_reg <= '0;
            check_cnt_reg <= '0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            carved_reg    <= carved_next;
            used_reg      <= used_next;
            last_reg      <= last_next;
            issue_cnt_reg <= issue_cnt_next;
            check_cnt_reg <= check_cnt_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        issue_idx_reg <= issue_idx_next;
        chk_idx_reg   <= chk_idx_next;
        status_reg    <= status_next;
        res_idx_reg   <= res_idx_next;
    end

    // ------------------------------------------------------------------------
    // result beat
    // ------------------------------------------------------------------------
    logic [SIZE_BITS-1:0]   left_w;
    logic [31:0]            left_ext;
    logic [31:0]            idx_ext;

    // memory left, floored at zero
    assign left_w   = (used_reg > total_reg) ? '0 : (total_reg - used_reg);
    assign left_ext = 32'(left_w);
    assign idx_ext  = 32'(res_idx_reg);

    assign busy        = state_reg != nfp_pkg::S_IDLE;
    assign done        = done_reg;
    assign status      = status_reg;
    assign part_index  = idx_ext[nfp_pkg::IDX_FIELD_W-1:0];
    assign memory_left = left_ext[nfp_pkg::MEM_FIELD_W-1:0];

endmodule

`default_nettype wire
